// ===== rtl/fgtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgtc_pkg: shared types, constants and helpers of the green-time controller
// Widths, membership breakpoints, register codes and reset values.
// ----------------------------------------------------------------------------
package fgtc_pkg;

	// fixed-point scaling of the crisp output
	localparam int FRAC_BITS = 8;

	// field widths
	localparam int COUNT_W = 8;
	localparam int TIME_W  = 8;
	localparam int DEG_W   = 5;
	localparam int PROD_W  = TIME_W + DEG_W;
	localparam int NUM_W   = PROD_W + 2;
	localparam int DEN_W   = DEG_W + 2;
	localparam int QUO_W   = 16;
	localparam int DVD_W   = DEN_W + QUO_W;

	// cycles from an accepted start to its done strobe
	localparam int LATENCY = 4 + QUO_W;

	// membership breakpoints and full degree
	localparam logic [COUNT_W-1:0] BP_A = 8'd20;
	localparam logic [COUNT_W-1:0] BP_B = 8'd40;
	localparam logic [COUNT_W-1:0] BP_C = 8'd60;
	localparam logic [COUNT_W-1:0] BP_D = 8'd80;
	localparam logic [DEG_W-1:0]   DEG_FULL = 5'd20;
	localparam logic [DEG_W-1:0]   DEG_NONE = 5'd0;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_SHORT   = 2'd0,
		CFG_TIME_MEDIUM  = 2'd1,
		CFG_TIME_LONG    = 2'd2,
		CFG_TIME_LONGEST = 2'd3
	} cfg_idx_t;

	// reset values of the consequent times, in seconds
	localparam logic [TIME_W-1:0] RST_TIME_SHORT   = 8'd5;
	localparam logic [TIME_W-1:0] RST_TIME_MEDIUM  = 8'd7;
	localparam logic [TIME_W-1:0] RST_TIME_LONG    = 8'd12;
	localparam logic [TIME_W-1:0] RST_TIME_LONGEST = 8'd15;

	typedef logic [DEG_W-1:0] deg_t;

	// memberships of one count
	typedef struct packed {
		deg_t lo;
		deg_t mid;
		deg_t hi;
	} memb_t;

	// rule group strengths
	typedef struct packed {
		deg_t w_short;
		deg_t w_medium;
		deg_t w_long;
		deg_t w_longest;
	} weights_t;

	// consequent times as one group
	typedef struct packed {
		logic [TIME_W-1:0] t_short;
		logic [TIME_W-1:0] t_medium;
		logic [TIME_W-1:0] t_long;
		logic [TIME_W-1:0] t_longest;
	} times_t;

	function automatic deg_t deg_min(input deg_t a, input deg_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic deg_t deg_max(input deg_t a, input deg_t b);
		return (a > b) ? a : b;
	endfunction

	// shoulder and trapezoid memberships, breakpoints inclusive
	function automatic memb_t fuzzify(input logic [COUNT_W-1:0] c);
		memb_t m;
		m.lo  = DEG_NONE;
		m.mid = DEG_NONE;
		m.hi  = DEG_NONE;
		if (c <= BP_A) begin
			m.lo = DEG_FULL;
		end else if (c < BP_B) begin
			m.lo  = DEG_W'(BP_B - c);
			m.mid = DEG_W'(c - BP_A);
		end else if (c <= BP_C) begin
			m.mid = DEG_FULL;
		end else if (c < BP_D) begin
			m.mid = DEG_W'(BP_D - c);
			m.hi  = DEG_W'(c - BP_C);
		end else begin
			m.hi = DEG_FULL;
		end
		return m;
	endfunction

endpackage

// ===== rtl/fuzzy_green_time_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_green_time_controller: fuzzy green-time controller top level
// Fuzzifies two car counts, applies nine min rules and four max groups,
// and returns the weighted-average green time of four singleton times.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: cars_waiting and cars_passing, taken at a clock edge with
//   start high and busy low. busy stays low, so a word can enter every cycle.
//   Result word: green_time in 1/256 s units, valid for one cycle while done
//   is high. The receiver has no back-pressure and must take it then.
//   The result passes through two stages of fuzzification and rules, two of
//   products and sums, and one stage per quotient bit of the 16-stage
//   divider. Throughput is one word per cycle; results leave in the order
//   the words came in.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one consequent
//   time (0 short, 1 medium, 2 long, 3 longest); cfg_ready is always high.
//   Write only while no word is in flight.
//   Reset: arst_n clears all pipeline valid bits and loads the default times
//   of 5, 7, 12 and 15 seconds.
// ----------------------------------------------------------------------------
module fuzzy_green_time_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [fgtc_pkg::COUNT_W-1:0]     cars_waiting,
	input  logic [fgtc_pkg::COUNT_W-1:0]     cars_passing,
	output logic                             done,
	output logic [fgtc_pkg::QUO_W-1:0]       green_time,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fgtc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fgtc_pkg::TIME_W-1:0]      cfg_data
);
	import fgtc_pkg::*;

	times_t           times_q;
	logic             in_valid;
	logic             w_valid;
	weights_t         weights;
	logic             sum_valid;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;

	// the pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_valid  = start && !busy;

	// consequent time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			times_q.t_short   <= RST_TIME_SHORT;
			times_q.t_medium  <= RST_TIME_MEDIUM;
			times_q.t_long    <= RST_TIME_LONG;
			times_q.t_longest <= RST_TIME_LONGEST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIME_SHORT:   times_q.t_short   <= cfg_data;
				CFG_TIME_MEDIUM:  times_q.t_medium  <= cfg_data;
				CFG_TIME_LONG:    times_q.t_long    <= cfg_data;
				CFG_TIME_LONGEST: times_q.t_longest <= cfg_data;
				default: ;
			endcase
		end
	end

	// memberships and rule strengths
	fgtc_rules u_rules (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.cars_waiting (cars_waiting),
		.cars_passing (cars_passing),
		.w_valid      (w_valid),
		.weights      (weights)
	);

	// weighted sums
	fgtc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_valid   (w_valid),
		.weights   (weights),
		.times     (times_q),
		.sum_valid (sum_valid),
		.num       (num),
		.den       (den)
	);

	// weighted average
	fgtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.num       (num),
		.den       (den),
		.q_valid   (done),
		.quotient  (green_time)
	);

endmodule

// ===== rtl/fgtc_rules.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgtc_rules: fuzzification and rule evaluation
// Stage 1 registers the memberships of both counts, stage 2 the min/max
// strengths of the four consequent groups.
// ----------------------------------------------------------------------------
module fgtc_rules (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [fgtc_pkg::COUNT_W-1:0]    cars_waiting,
	input  logic [fgtc_pkg::COUNT_W-1:0]    cars_passing,
	output logic                            w_valid,
	output fgtc_pkg::weights_t              weights
);
	import fgtc_pkg::*;

	logic    valid_s1;
	memb_t   wait_s1;
	memb_t   pass_s1;
	logic    valid_s2;
	weights_t wt_s2;
	weights_t wt_next;

	// stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1 memberships
	always_ff @(posedge clk) begin
		wait_s1 <= fuzzify(cars_waiting);
		pass_s1 <= fuzzify(cars_passing);
	end

	// rule mins and group maxes
	always_comb begin
		wt_next.w_short   = deg_max(deg_min(wait_s1.lo, pass_s1.mid),
			deg_min(wait_s1.lo, pass_s1.hi));
		wt_next.w_medium  = deg_max(
			deg_max(deg_min(wait_s1.lo, pass_s1.lo), deg_min(wait_s1.mid, pass_s1.mid)),
			deg_max(deg_min(wait_s1.mid, pass_s1.hi), deg_min(wait_s1.hi, pass_s1.hi)));
		wt_next.w_long    = deg_max(deg_min(wait_s1.mid, pass_s1.lo),
			deg_min(wait_s1.hi, pass_s1.mid));
		wt_next.w_longest = deg_min(wait_s1.hi, pass_s1.lo);
	end

	// stage 2 strengths
	always_ff @(posedge clk) begin
		wt_s2 <= wt_next;
	end

	assign w_valid = valid_s2;
	assign weights = wt_s2;

endmodule

// ===== rtl/fgtc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgtc_mac: weighted sums for the defuzzifier
// Stage 3 registers the four time-by-strength products, stage 4 the
// numerator and the total strength.
// ----------------------------------------------------------------------------
module fgtc_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          w_valid,
	input  fgtc_pkg::weights_t            weights,
	input  fgtc_pkg::times_t              times,
	output logic                          sum_valid,
	output logic [fgtc_pkg::NUM_W-1:0]    num,
	output logic [fgtc_pkg::DEN_W-1:0]    den
);
	import fgtc_pkg::*;

	logic              valid_s3;
	logic [PROD_W-1:0] p_short_s3;
	logic [PROD_W-1:0] p_medium_s3;
	logic [PROD_W-1:0] p_long_s3;
	logic [PROD_W-1:0] p_longest_s3;
	weights_t          wt_s3;
	logic              valid_s4;
	logic [NUM_W-1:0]  num_s4;
	logic [DEN_W-1:0]  den_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= w_valid;
			valid_s4 <= valid_s3;
		end
	end

	// stage 3 products
	always_ff @(posedge clk) begin
		p_short_s3   <= PROD_W'(times.t_short)   * PROD_W'(weights.w_short);
		p_medium_s3  <= PROD_W'(times.t_medium)  * PROD_W'(weights.w_medium);
		p_long_s3    <= PROD_W'(times.t_long)    * PROD_W'(weights.w_long);
		p_longest_s3 <= PROD_W'(times.t_longest) * PROD_W'(weights.w_longest);
		wt_s3        <= weights;
	end

	// stage 4 sums
	always_ff @(posedge clk) begin
		num_s4 <= NUM_W'(p_short_s3) + NUM_W'(p_medium_s3)
			+ NUM_W'(p_long_s3) + NUM_W'(p_longest_s3);
		den_s4 <= DEN_W'(wt_s3.w_short) + DEN_W'(wt_s3.w_medium)
			+ DEN_W'(wt_s3.w_long) + DEN_W'(wt_s3.w_longest);
	end

	assign sum_valid = valid_s4;
	assign num       = num_s4;
	assign den       = den_s4;

endmodule

// ===== rtl/fgtc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgtc_div: pipelined restoring divider
// One quotient bit per stage over QUO_W stages; the scaled numerator is
// split so the first partial remainder is already below the divisor.
// A zero total strength forces a zero result.
// ----------------------------------------------------------------------------
module fgtc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sum_valid,
	input  logic [fgtc_pkg::NUM_W-1:0]    num,
	input  logic [fgtc_pkg::DEN_W-1:0]    den,
	output logic                          q_valid,
	output logic [fgtc_pkg::QUO_W-1:0]    quotient
);
	import fgtc_pkg::*;

	logic [DVD_W-1:0] dvd;
	logic             dv_valid_s [0:QUO_W];
	logic [DEN_W-1:0] dv_rem_s   [0:QUO_W];
	logic [QUO_W-1:0] dv_low_s   [0:QUO_W];
	logic [QUO_W-1:0] dv_quo_s   [0:QUO_W];
	logic [DEN_W-1:0] dv_den_s   [0:QUO_W];
	logic             dv_nz_s    [0:QUO_W];

	// scaled dividend feeds the first step without a register
	assign dvd          = DVD_W'(num) << FRAC_BITS;
	assign dv_valid_s[0] = sum_valid;
	assign dv_rem_s[0]   = dvd[DVD_W-1:QUO_W];
	assign dv_low_s[0]   = dvd[QUO_W-1:0];
	assign dv_quo_s[0]   = '0;
	assign dv_den_s[0]   = den;
	assign dv_nz_s[0]    = (den != '0);

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           take;

		// shift in the next dividend bit and try the subtract
		assign trial = {dv_rem_s[k], dv_low_s[k][QUO_W-1]};
		assign take  = (trial >= {1'b0, dv_den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[k+1] <= 1'b0;
			end else begin
				dv_valid_s[k+1] <= dv_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[k+1] <= take ? DEN_W'(trial - {1'b0, dv_den_s[k]})
				: DEN_W'(trial);
			dv_low_s[k+1] <= {dv_low_s[k][QUO_W-2:0], 1'b0};
			dv_quo_s[k+1] <= {dv_quo_s[k][QUO_W-2:0], take};
			dv_den_s[k+1] <= dv_den_s[k];
			dv_nz_s[k+1]  <= dv_nz_s[k];
		end
	end

	assign q_valid  = dv_valid_s[QUO_W];
	assign quotient = dv_nz_s[QUO_W] ? dv_quo_s[QUO_W] : '0;

endmodule

// ===== rtl/fgtc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgtc_checker: port-level checks of the green-time controller
// Fixed latency in both directions and the output range.
// ----------------------------------------------------------------------------
module fgtc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [fgtc_pkg::QUO_W-1:0]       green_time
);
	import fgtc_pkg::*;

	localparam logic [QUO_W-1:0] GREEN_MAX = QUO_W'(255) << FRAC_BITS;

	// every accepted word yields a result after the fixed latency
	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no result at the fixed latency");

	// no result without a word accepted the fixed latency earlier
	a_done_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted word");

	// weighted average never exceeds the largest representable time of 255 s
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (green_time <= GREEN_MAX))
		else $error("green time above the largest possible singleton");

endmodule

bind fuzzy_green_time_controller fgtc_checker u_fgtc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.green_time (green_time)
);
